FILE: sv/tdf_pkg.sv
// Shared types, constants and helpers for the fhan tracking differentiator.
// Used by every module of the block; has no dependencies of its own.
package tdf_pkg;

    localparam int VAL_W        = 48;
    localparam int R_W          = 40;
    localparam int H_W          = 25;
    localparam int CFG_W        = 40;
    localparam int CFG_IDX_W    = 2;
    localparam int WORD_W       = 2 * VAL_W;
    localparam int CHANNELS_DEF = 8;

    localparam int MUL_A_W = 53;
    localparam int MUL_B_W = 44;
    localparam int MUL_DIG = 4;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int SQ_PAIRS = 47;
    localparam int DIV_Q_W  = 40;
    localparam int DIV_D_W  = 40;

    localparam logic [H_W-1:0] ONE_Q24         = 25'h100_0000;
    localparam logic [R_W-1:0] SPEED_RESET     = 40'd655359934464;
    localparam logic [H_W-1:0] FILTER_RESET    = 25'd8388608;
    localparam logic [H_W-1:0] STEP_RESET      = 25'd9227469;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd2;

    typedef struct packed {
        logic [2:0]              channel;
        logic signed [VAL_W-1:0] target;
    } sample_t;

    typedef struct packed {
        logic [2:0]              channel_out;
        logic signed [VAL_W-1:0] position;
        logic signed [VAL_W-1:0] velocity;
        logic signed [VAL_W-1:0] acceleration;
    } result_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_HSQ,
        ST_DMUL,
        ST_A0,
        ST_YCALC,
        ST_YMAG,
        ST_BIG,
        ST_SQRT,
        ST_AFIX,
        ST_ACMP,
        ST_RMUL,
        ST_DIV,
        ST_PMUL,
        ST_VMUL,
        ST_WRITE
    } state_t;

    // magnitude of a 48-bit two's complement value
    function automatic logic [VAL_W-1:0] mag48(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] n;
        n = -v;
        return v[VAL_W-1] ? n : v;
    endfunction

    // saturate a 50-bit two's complement value to 48 bits
    function automatic logic [VAL_W-1:0] sat48(input logic [VAL_W+1:0] v);
        logic [VAL_W-1:0] r;
        if (v[VAL_W+1:VAL_W-1] == 3'b000 || v[VAL_W+1:VAL_W-1] == 3'b111) begin
            r = v[VAL_W-1:0];
        end else if (v[VAL_W+1]) begin
            r = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

FILE: sv/tracking_differentiator_fhan.sv
// One transaction at a time: the sequencer steps through the shared multiplier, square
// root and divider, taking the square-root and divide paths only when fhan needs them;
// an unused channel goes straight to the result. The next transaction is accepted once
// the sequencer is back in idle after the result loads.
// Reset: r, h1, h2 defaults; states read zero.
// Depends on tdf_pkg, tdf_state_mem, tdf_mul, tdf_sqrt, tdf_div.
module tracking_differentiator_fhan #(
    parameter int CHANNELS = tdf_pkg::CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  tdf_pkg::sample_t              sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output tdf_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [tdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tdf_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int VW = tdf_pkg::VAL_W;
    localparam int PW = tdf_pkg::MUL_P_W;

    // configuration
    logic [tdf_pkg::R_W-1:0] speed_reg;
    logic [tdf_pkg::H_W-1:0] filter_reg;
    logic [tdf_pkg::H_W-1:0] step_reg;
    logic [tdf_pkg::H_W-1:0] h1;
    logic [tdf_pkg::H_W-1:0] h2;

    // sequencer
    tdf_pkg::state_t state_reg, state_next;
    logic            issued_reg;
    logic            mul_use, sqrt_use, div_use;
    logic            mul_start, sqrt_start, div_start;
    logic            mul_done, sqrt_done, div_done, step_done;
    logic [tdf_pkg::MUL_A_W-1:0] mul_a;
    logic [tdf_pkg::MUL_B_W-1:0] mul_b;
    logic [PW-1:0]               mul_prod;
    logic [tdf_pkg::SQ_PAIRS-1:0] sqrt_root;
    logic [tdf_pkg::DIV_Q_W-1:0]  div_quo;

    // datapath
    logic [2:0]     ch_reg;
    logic [VW-1:0]  tgt_reg;
    logic           oob_reg;
    logic [VW-1:0]  pos_reg, vel_reg;
    logic [24:0]    hsq_reg;
    logic [39:0]    d_reg;
    logic [48:0]    a0_reg;
    logic [49:0]    y_reg;
    logic [48:0]    ya_reg;
    logic           lin_reg;
    logic [45:0]    half_reg;
    logic [49:0]    a_reg;
    logic [39:0]    am_reg;
    logic [VW-1:0]  f_reg;
    logic [VW-1:0]  pos_new_reg, vel_new_reg;

    logic           accept;
    logic           oob_in;
    logic           out_free;
    logic           out_load;
    logic           result_valid_reg;
    tdf_pkg::result_t result_reg;
    tdf_pkg::mem_ctl_t mem_ctl;
    logic [tdf_pkg::WORD_W-1:0] mem_rdata;

    // combinational helpers
    logic [VW-1:0]  prod_q24;
    logic [49:0]    y_sum;
    logic [49:0]    y_neg;
    logic [48:0]    ya;
    logic [46:0]    root_diff;
    logic [49:0]    a_add;
    logic [49:0]    a_sum;
    logic [49:0]    a_neg;
    logic [48:0]    am;
    logic [49:0]    step_delta;
    logic [VW-1:0]  quo_f;

    assign h1 = (filter_reg > tdf_pkg::ONE_Q24) ? tdf_pkg::ONE_Q24 : filter_reg;
    assign h2 = (step_reg > tdf_pkg::ONE_Q24) ? tdf_pkg::ONE_Q24 : step_reg;

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != tdf_pkg::ST_IDLE);
    assign oob_in       = (32'(sample.channel) >= CHANNELS);
    assign out_free     = !result_valid_reg || !result_stall;
    assign out_load     = (state_reg == tdf_pkg::ST_WRITE) && out_free;

    // configuration writes: the user must write only while idle; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            speed_reg  <= tdf_pkg::SPEED_RESET;
            filter_reg <= tdf_pkg::FILTER_RESET;
            step_reg   <= tdf_pkg::STEP_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tdf_pkg::CFG_SPEED:  speed_reg  <= cfg_data[tdf_pkg::R_W-1:0];
                tdf_pkg::CFG_FILTER: filter_reg <= cfg_data[tdf_pkg::H_W-1:0];
                tdf_pkg::CFG_STEP:   step_reg   <= cfg_data[tdf_pkg::H_W-1:0];
                default: ;
            endcase
        end
    end

    // channel state store
    tdf_state_mem #(
        .CHANNELS (CHANNELS),
        .AW       (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .rd_addr (AW'(sample.channel)),
        .wr_addr (AW'(ch_reg)),
        .wdata   ({pos_new_reg, vel_new_reg}),
        .rdata   (mem_rdata)
    );

    tdf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    tdf_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .val   (mul_prod[2*tdf_pkg::SQ_PAIRS-1:0]),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    tdf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_prod[tdf_pkg::DIV_D_W+tdf_pkg::DIV_Q_W-1:0]),
        .den   (d_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign mul_start  = mul_use && !issued_reg;
    assign sqrt_start = sqrt_use && !issued_reg;
    assign div_start  = div_use && !issued_reg;
    assign step_done  = mul_done || sqrt_done || div_done;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tdf_pkg::ST_IDLE:  if (accept) state_next = oob_in ? tdf_pkg::ST_WRITE
                                                                : tdf_pkg::ST_LOAD;
            tdf_pkg::ST_LOAD:  state_next = tdf_pkg::ST_HSQ;
            tdf_pkg::ST_HSQ:   if (step_done) state_next = tdf_pkg::ST_DMUL;
            tdf_pkg::ST_DMUL:  if (step_done) state_next = tdf_pkg::ST_A0;
            tdf_pkg::ST_A0:    if (step_done) state_next = tdf_pkg::ST_YCALC;
            tdf_pkg::ST_YCALC: state_next = tdf_pkg::ST_YMAG;
            tdf_pkg::ST_YMAG:  state_next = (ya < 49'(d_reg)) ? tdf_pkg::ST_AFIX
                                                               : tdf_pkg::ST_BIG;
            tdf_pkg::ST_BIG:   if (step_done) state_next = tdf_pkg::ST_SQRT;
            tdf_pkg::ST_SQRT:  if (step_done) state_next = tdf_pkg::ST_AFIX;
            tdf_pkg::ST_AFIX:  state_next = tdf_pkg::ST_ACMP;
            tdf_pkg::ST_ACMP:  state_next = (am < 49'(d_reg)) ? tdf_pkg::ST_RMUL
                                                               : tdf_pkg::ST_PMUL;
            tdf_pkg::ST_RMUL:  if (step_done) state_next = tdf_pkg::ST_DIV;
            tdf_pkg::ST_DIV:   if (step_done) state_next = tdf_pkg::ST_PMUL;
            tdf_pkg::ST_PMUL:  if (step_done) state_next = tdf_pkg::ST_VMUL;
            tdf_pkg::ST_VMUL:  if (step_done) state_next = tdf_pkg::ST_WRITE;
            tdf_pkg::ST_WRITE: if (out_free) state_next = tdf_pkg::ST_IDLE;
            default:           state_next = tdf_pkg::ST_IDLE;
        endcase
    end

    // unit selection and operands per step
    always_comb begin
        mul_use  = 1'b0;
        sqrt_use = 1'b0;
        div_use  = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        mem_ctl  = '{rd: accept && !oob_in, wr: out_load && !oob_reg};
        unique case (state_reg)
            tdf_pkg::ST_HSQ: begin
                mul_use = 1'b1;
                mul_a   = {28'b0, h1};
                mul_b   = {19'b0, h1};
            end
            tdf_pkg::ST_DMUL: begin
                mul_use = 1'b1;
                mul_a   = {13'b0, speed_reg};
                mul_b   = {19'b0, hsq_reg};
            end
            tdf_pkg::ST_A0: begin
                mul_use = 1'b1;
                mul_a   = {5'b0, tdf_pkg::mag48(vel_reg)};
                mul_b   = {19'b0, h1};
            end
            tdf_pkg::ST_BIG: begin
                // d * (d + 8|y|)
                mul_use = 1'b1;
                mul_a   = {13'b0, d_reg} + {1'b0, ya_reg, 3'b000};
                mul_b   = {4'b0, d_reg};
            end
            tdf_pkg::ST_SQRT: sqrt_use = 1'b1;
            tdf_pkg::ST_RMUL: begin
                mul_use = 1'b1;
                mul_a   = {13'b0, speed_reg};
                mul_b   = {4'b0, am_reg};
            end
            tdf_pkg::ST_DIV: div_use = 1'b1;
            tdf_pkg::ST_PMUL: begin
                mul_use = 1'b1;
                mul_a   = {5'b0, tdf_pkg::mag48(vel_reg)};
                mul_b   = {19'b0, h2};
            end
            tdf_pkg::ST_VMUL: begin
                mul_use = 1'b1;
                mul_a   = {5'b0, tdf_pkg::mag48(f_reg)};
                mul_b   = {19'b0, h2};
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg        <= tdf_pkg::ST_IDLE;
            issued_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (step_done) begin
                issued_reg <= 1'b0;
            end else if (mul_start || sqrt_start || div_start) begin
                issued_reg <= 1'b1;
            end
            if (out_load) begin
                result_valid_reg <= 1'b1;
            end else if (!result_stall) begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // arithmetic between steps
    always_comb begin
        prod_q24  = mul_prod[VW+23:24];
        y_sum     = {{2{pos_reg[VW-1]}}, pos_reg} - {{2{tgt_reg[VW-1]}}, tgt_reg}
                    + {a0_reg[48], a0_reg};
        y_neg     = -y_reg;
        ya        = y_reg[49] ? y_neg[48:0] : y_reg[48:0];
        root_diff = (sqrt_root >= 47'(d_reg)) ? sqrt_root - 47'(d_reg) : '0;
        // linear zone adds y; otherwise move toward y by half of (root - d)
        if (lin_reg) begin
            a_add = y_reg;
        end else if (y_reg[49]) begin
            a_add = -{4'b0, half_reg};
        end else begin
            a_add = {4'b0, half_reg};
        end
        a_sum = {a0_reg[48], a0_reg} + a_add;
        a_neg = -a_reg;
        am    = a_reg[49] ? a_neg[48:0] : a_reg[48:0];
        // f opposes the sign of a
        quo_f = a_reg[49] ? {8'b0, div_quo} : -{8'b0, div_quo};
        if (state_reg == tdf_pkg::ST_PMUL) begin
            step_delta = vel_reg[VW-1] ? -{2'b0, prod_q24} : {2'b0, prod_q24};
        end else begin
            step_delta = f_reg[VW-1] ? -{2'b0, prod_q24} : {2'b0, prod_q24};
        end
    end

    // payload registers
    always_ff @(posedge clk) begin
        if (accept) begin
            ch_reg  <= sample.channel;
            tgt_reg <= sample.target;
            oob_reg <= oob_in;
        end
        case (state_reg)
            tdf_pkg::ST_LOAD: begin
                pos_reg <= mem_rdata[tdf_pkg::WORD_W-1:VW];
                vel_reg <= mem_rdata[VW-1:0];
            end
            tdf_pkg::ST_HSQ: if (mul_done) hsq_reg <= mul_prod[48:24];
            tdf_pkg::ST_DMUL: begin
                // floor d at one LSB
                if (mul_done) d_reg <= (mul_prod[63:24] == '0) ? 40'd1 : mul_prod[63:24];
            end
            tdf_pkg::ST_A0: begin
                if (mul_done) begin
                    a0_reg <= vel_reg[VW-1] ? -{1'b0, prod_q24} : {1'b0, prod_q24};
                end
            end
            tdf_pkg::ST_YCALC: y_reg <= (y_sum == '0) ? 50'd1 : y_sum;
            tdf_pkg::ST_YMAG: begin
                ya_reg  <= ya;
                lin_reg <= ya < 49'(d_reg);
            end
            tdf_pkg::ST_SQRT: if (sqrt_done) half_reg <= root_diff[46:1];
            tdf_pkg::ST_AFIX: a_reg <= (a_sum == '0) ? 50'd1 : a_sum;
            tdf_pkg::ST_ACMP: begin
                am_reg    <= am[39:0];
                f_reg     <= a_reg[49] ? {8'b0, speed_reg} : -{8'b0, speed_reg};
            end
            tdf_pkg::ST_DIV: if (div_done) f_reg <= quo_f;
            tdf_pkg::ST_PMUL: begin
                if (mul_done) begin
                    pos_new_reg <= tdf_pkg::sat48({{2{pos_reg[VW-1]}}, pos_reg} + step_delta);
                end
            end
            tdf_pkg::ST_VMUL: begin
                if (mul_done) begin
                    vel_new_reg <= tdf_pkg::sat48({{2{vel_reg[VW-1]}}, vel_reg} + step_delta);
                end
            end
            default: ;
        endcase
        if (out_load) begin
            result_reg.channel_out  <= ch_reg;
            result_reg.position     <= oob_reg ? '0 : pos_new_reg;
            result_reg.velocity     <= oob_reg ? '0 : vel_new_reg;
            result_reg.acceleration <= oob_reg ? '0 : f_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    // a unit reports completion only for a step that was launched
    a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
        step_done |-> issued_reg)
        else $error("unit completion without a launched step");

    // the divide sees a numerator below d * 2^40, so the quotient fits
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (mul_prod[79:40] < d_reg))
        else $error("divider numerator out of range");

    // an accepted transaction goes to the memory read or straight to the result
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == tdf_pkg::ST_LOAD || state_reg == tdf_pkg::ST_WRITE))
        else $error("accepted transaction took a wrong path");

    // d is floored at one LSB before any use
    a_d_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tdf_pkg::ST_A0 && mul_start) |=> (d_reg != '0))
        else $error("d reached zero");
`endif

endmodule

FILE: sv/tdf_state_mem.sv
// Per-channel position/velocity store: one synchronous RAM, registered read.
// Valid bits make never-written entries read as zero. Uses tdf_pkg.
module tdf_state_mem #(
    parameter int CHANNELS = tdf_pkg::CHANNELS_DEF,
    parameter int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tdf_pkg::mem_ctl_t          ctl,
    input  logic [AW-1:0]              rd_addr,
    input  logic [AW-1:0]              wr_addr,
    input  logic [tdf_pkg::WORD_W-1:0] wdata,
    output logic [tdf_pkg::WORD_W-1:0] rdata
);

    logic [tdf_pkg::WORD_W-1:0] mem [CHANNELS];
    logic [tdf_pkg::WORD_W-1:0] raw_reg;
    logic [CHANNELS-1:0]        valid_reg;
    logic                       rvalid_reg;

    always_ff @(posedge clk) begin
        if (ctl.wr) begin
            mem[wr_addr] <= wdata;
        end
        if (ctl.rd) begin
            raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (ctl.wr) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd) begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rdata = rvalid_reg ? raw_reg : '0;

endmodule

FILE: sv/tdf_mul.sv
// Iterative unsigned multiplier, one radix-16 digit of b per cycle.
// Widths from tdf_pkg.
module tdf_mul #(
    parameter int A_W = tdf_pkg::MUL_A_W,
    parameter int B_W = tdf_pkg::MUL_B_W,
    parameter int DIG = tdf_pkg::MUL_DIG
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] prod
);

    localparam int P_W   = A_W + B_W;
    localparam int STEPS = B_W / DIG;
    localparam int CW    = $clog2(STEPS + 1);

    logic           run_reg;
    logic           done_reg;
    logic [CW-1:0]  cnt_reg;
    logic [P_W-1:0] a_sh_reg;
    logic [B_W-1:0] b_sh_reg;
    logic [P_W-1:0] acc_reg;
    logic [P_W-1:0] part;

    assign part = a_sh_reg * {{(P_W-DIG){1'b0}}, b_sh_reg[DIG-1:0]};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(STEPS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            a_sh_reg <= {{B_W{1'b0}}, a};
            b_sh_reg <= b;
            acc_reg  <= '0;
        end else if (run_reg) begin
            acc_reg  <= acc_reg + part;
            a_sh_reg <= a_sh_reg << DIG;
            b_sh_reg <= b_sh_reg >> DIG;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

FILE: sv/tdf_sqrt.sv
// Restoring integer square root, one result bit per cycle.
// Width from tdf_pkg.
module tdf_sqrt #(
    parameter int PAIRS = tdf_pkg::SQ_PAIRS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2*PAIRS-1:0] val,
    output logic               done,
    output logic [PAIRS-1:0]   root
);

    localparam int RW = PAIRS + 4;
    localparam int CW = $clog2(PAIRS + 1);

    logic               run_reg;
    logic               done_reg;
    logic [CW-1:0]      cnt_reg;
    logic [2*PAIRS-1:0] val_sh_reg;
    logic [RW-1:0]      rem_reg;
    logic [PAIRS-1:0]   root_reg;
    logic [RW-1:0]      rem_sh;
    logic [RW-1:0]      trial;
    logic               ge;

    assign rem_sh = {rem_reg[RW-3:0], val_sh_reg[2*PAIRS-1:2*PAIRS-2]};
    assign trial  = RW'({root_reg, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(PAIRS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            val_sh_reg <= val;
            rem_reg    <= '0;
            root_reg   <= '0;
        end else if (run_reg) begin
            val_sh_reg <= val_sh_reg << 2;
            rem_reg    <= ge ? rem_sh - trial : rem_sh;
            root_reg   <= {root_reg[PAIRS-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: sv/tdf_div.sv
// Restoring divider for a numerator known to give a quotient of Q_W bits.
// One quotient bit per cycle. Widths from tdf_pkg.
module tdf_div #(
    parameter int Q_W = tdf_pkg::DIV_Q_W,
    parameter int D_W = tdf_pkg::DIV_D_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [D_W+Q_W-1:0] num,
    input  logic [D_W-1:0]     den,
    output logic               done,
    output logic [Q_W-1:0]     quo
);

    localparam int CW = $clog2(Q_W + 1);

    logic           run_reg;
    logic           done_reg;
    logic [CW-1:0]  cnt_reg;
    logic [Q_W-1:0] low_reg;
    logic [D_W-1:0] rem_reg;
    logic [D_W-1:0] den_reg;
    logic [Q_W-1:0] quo_reg;
    logic [D_W:0]   rem_sh;
    logic [D_W:0]   diff;
    logic           ge;

    assign rem_sh = {rem_reg, low_reg[Q_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(Q_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            rem_reg <= num[D_W+Q_W-1:Q_W];
            low_reg <= num[Q_W-1:0];
            den_reg <= den;
            quo_reg <= '0;
        end else if (run_reg) begin
            rem_reg <= ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
            low_reg <= low_reg << 1;
            quo_reg <= {quo_reg[Q_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
